@@ rtl/qed_pkg.sv @@
package qed_pkg;

    // Character codes
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [3:0] HEX_TEN       = 4'hA;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Number of bytes a command emits
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // One decoded command: up to three bytes, last flag goes on the final one
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic            last;
    } cmd_t;

    // Front to queue write request
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } qwr_t;

    // Queue to back read side
    typedef struct packed {
        logic empty;
        cmd_t head;
    } qrd_t;

    // Hex digit value; bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
            return {1'b0, d[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h41;
            return {1'b0, HEX_TEN + d[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h61;
            return {1'b0, HEX_TEN + d[3:0]};
        end
        return 5'h10;
    endfunction

    // Plain byte: underscore maps to space
    function automatic logic [7:0] plain(logic [7:0] c);
        return (c == CH_UNDERSCORE) ? CH_SPACE : c;
    endfunction

endpackage

@@ rtl/qed_in_if.sv @@
interface qed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/qed_out_if.sv @@
interface qed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ rtl/qed_front.sv @@
module qed_front (
    input  logic                 clk,
    input  logic                 rst_n,
    qed_in_if.sink               in_ch,
    input  logic                 full,
    output qed_pkg::qwr_t        wr
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_EQ,
        PH_DIGIT
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       take;
    logic [4:0] hi, lo;

    assign in_ch.ready = !full;
    assign take        = in_ch.valid && !full;
    assign hi          = qed_pkg::hex_val(held_reg);
    assign lo          = qed_pkg::hex_val(in_ch.in_byte);

    // Classify the item and build the command for the back end
    always_comb
    begin
        phase_next   = phase_reg;
        held_next    = held_reg;
        wr.push      = 1'b0;
        wr.cmd.count = qed_pkg::CNT_ONE;
        wr.cmd.bytes = {8'h00, 8'h00, qed_pkg::plain(in_ch.in_byte)};
        wr.cmd.last  = in_ch.in_last;
        if (take)
        begin
            unique case (phase_reg)
                PH_EQ:
                begin
                    if (in_ch.in_last)
                    begin
                        // equals as second-to-last byte goes out literally
                        phase_next   = PH_IDLE;
                        wr.push      = 1'b1;
                        wr.cmd.count = qed_pkg::CNT_TWO;
                        wr.cmd.bytes = {8'h00, qed_pkg::plain(in_ch.in_byte),
                                        qed_pkg::CH_EQUALS};
                    end
                    else
                    begin
                        held_next  = in_ch.in_byte;
                        phase_next = PH_DIGIT;
                    end
                end
                PH_DIGIT:
                begin
                    phase_next = PH_IDLE;
                    wr.push    = 1'b1;
                    if (!hi[4] && !lo[4])
                    begin
                        wr.cmd.count = qed_pkg::CNT_ONE;
                        wr.cmd.bytes = {8'h00, 8'h00, hi[3:0], lo[3:0]};
                    end
                    else
                    begin
                        // bad escape: raw bytes pass through
                        wr.cmd.count = qed_pkg::CNT_THREE;
                        wr.cmd.bytes = {in_ch.in_byte, held_reg, qed_pkg::CH_EQUALS};
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (in_ch.in_byte == qed_pkg::CH_EQUALS && !in_ch.in_last)
                        phase_next = PH_EQ;
                    else
                        wr.push = 1'b1;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

@@ rtl/qed_queue.sv @@
module qed_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  qed_pkg::qwr_t  wr,
    input  logic           pop,
    output logic           full,
    output qed_pkg::qrd_t  rd
);

    qed_pkg::cmd_t                    mem_reg [qed_pkg::QDEPTH];
    logic [qed_pkg::QPTR_W-1:0]       wptr_reg, wptr_next;
    logic [qed_pkg::QPTR_W-1:0]       rptr_reg, rptr_next;
    logic [qed_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                             do_push, do_pop;

    assign full     = (cnt_reg == qed_pkg::QCNT_W'(qed_pkg::QDEPTH));
    assign rd.empty = (cnt_reg == '0);
    assign rd.head  = mem_reg[rptr_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && !rd.empty;

    // Pointer and count update
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
            wptr_next = (wptr_reg == qed_pkg::QPTR_W'(qed_pkg::QDEPTH - 1)) ?
                        '0 : wptr_reg + 1'b1;
        if (do_pop)
            rptr_next = (rptr_reg == qed_pkg::QPTR_W'(qed_pkg::QDEPTH - 1)) ?
                        '0 : rptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= wr.cmd;
    end

endmodule

@@ rtl/qed_back.sv @@
module qed_back (
    input  logic           clk,
    input  logic           rst_n,
    input  qed_pkg::qrd_t  rd,
    output logic           pop,
    qed_out_if.source      out_ch
);

    qed_pkg::cmd_t cmd_reg;
    logic          cmd_valid_reg;
    logic [1:0]    idx_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          out_free, emit, final_byte, load;

    assign out_free   = !out_valid_reg || out_ch.ready;
    assign emit       = cmd_valid_reg && out_free;
    assign final_byte = (idx_reg == cmd_reg.count - 2'd1);
    assign load       = (!cmd_valid_reg || (emit && final_byte)) && !rd.empty;
    assign pop        = load;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;

    // Command register and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            cmd_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end
        else if (emit)
        begin
            if (final_byte)
                cmd_valid_reg <= 1'b0;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= rd.head;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= cmd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= cmd_reg.bytes[idx_reg];
            out_last_reg <= cmd_reg.last && final_byte;
        end
    end

endmodule

@@ rtl/q_encoding_byte_decoder.sv @@
// Channel   Modport   Fields               Handshake
// in_ch     sink      in_byte, in_last     valid / ready
// out_ch    source    out_byte, out_last   valid / ready
//
// Takes one byte per cycle unless the command queue is full; each byte yields 0 to 3
// output bytes, one per cycle unless out_ch.ready stalls. The byte completing a command
// leaves via queue entry, command register and output register; escape bytes before
// it emit nothing. Output byte register sets the pace: bad escapes hold the back end.
// in_ch.ready drops only when the 2-entry command queue is full.
// rst_n clears the escape phase, queue pointers and valid flags asynchronously.
module q_encoding_byte_decoder (
    input  logic       clk,
    input  logic       rst_n,
    qed_in_if.sink     in_ch,
    qed_out_if.source  out_ch
);

    qed_pkg::qwr_t wr;
    qed_pkg::qrd_t rd;
    logic          full;
    logic          pop;

    qed_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .full  (full),
        .wr    (wr)
    );

    qed_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .pop   (pop),
        .full  (full),
        .rd    (rd)
    );

    qed_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (rd),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

@@ rtl/qed_checker.sv @@
module qed_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    logic seen_in_reg;

    // Remember that some input item has been taken since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_in_reg <= 1'b0;
        else if (in_valid && in_ready)
            seen_in_reg <= 1'b1;
    end

    // A stalled output item stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output item changed while stalled");

    // Nothing comes out right after reset
    assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

    // No output item before any input item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_in_reg)
    else $error("output without earlier input");

    // Handshake and payload of a valid output are known
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid}) && (!out_valid || !$isunknown({out_byte, out_last})))
    else $error("unknown handshake or output payload");

endmodule

bind q_encoding_byte_decoder qed_checker u_qed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last)
);

@@ sim/qed_stream_checker.sv @@
`timescale 1ns / 1ps

module qed_stream_checker (
    input  logic clk,
    input  logic rst_n,
    qed_in_if    in_ch,
    qed_out_if   out_ch,
    output int   fail_count,
    output int   pending
);

    // Escape tracking: idle, '=' seen, '=' and first digit seen
    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_EQ,
        ESC_HI
    } esc_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    esc_phase_t esc = ESC_NONE;
    logic [7:0] hi_char = '0;
    dec_byte_t  decoded_q[$];
    int         errs = 0;

    assign fail_count = errs;

    // Value of a hex digit in the low nibble; bit 4 flags a non-hex byte
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
            return {1'b0, c[3:0]};
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    // Advance the escape tracker by one raw byte and queue what it yields
    task automatic decode_byte(input logic [7:0] c, input logic last);
        logic [7:0] plain_c;
        logic [4:0] hi_n;
        logic [4:0] lo_n;
        plain_c = (c == qed_pkg::CH_UNDERSCORE) ? qed_pkg::CH_SPACE : c;
        case (esc)
            ESC_EQ:
            begin
                if (last)
                begin
                    // '=' was second to last: literal, then the byte as usual
                    decoded_q.push_back(dec_byte_t'{qed_pkg::CH_EQUALS, 1'b0});
                    decoded_q.push_back(dec_byte_t'{plain_c, 1'b1});
                    esc = ESC_NONE;
                end
                else
                begin
                    hi_char = c;
                    esc     = ESC_HI;
                end
            end
            ESC_HI:
            begin
                esc  = ESC_NONE;
                hi_n = nibble_of(hi_char);
                lo_n = nibble_of(c);
                if (!hi_n[4] && !lo_n[4])
                    decoded_q.push_back(dec_byte_t'{{hi_n[3:0], lo_n[3:0]}, last});
                else
                begin
                    // bad escape: all three raw bytes go out untouched
                    decoded_q.push_back(dec_byte_t'{qed_pkg::CH_EQUALS, 1'b0});
                    decoded_q.push_back(dec_byte_t'{hi_char, 1'b0});
                    decoded_q.push_back(dec_byte_t'{c, last});
                end
            end
            default:
            begin
                esc = ESC_NONE;
                if (c == qed_pkg::CH_EQUALS && !last)
                    esc = ESC_EQ;
                else
                    decoded_q.push_back(dec_byte_t'{plain_c, last});
            end
        endcase
    endtask

    // Predict on accepted input, compare on accepted output
    always @(posedge clk)
    begin
        dec_byte_t want;
        if (!rst_n)
        begin
            esc     = ESC_NONE;
            hi_char = '0;
            decoded_q.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                decode_byte(in_ch.in_byte, in_ch.in_last);
            if (out_ch.valid && out_ch.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("out_byte: expected nothing, got %02h", out_ch.out_byte);
                    errs++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_ch.out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.data, out_ch.out_byte);
                        errs++;
                    end
                    if (out_ch.out_last !== want.last)
                    begin
                        $error("out_last: expected %0b, got %0b",
                               want.last, out_ch.out_last);
                        errs++;
                    end
                end
            end
        end
        pending <= decoded_q.size();
    end

endmodule

@@ sim/tb_q_encoding_byte_decoder.sv @@
`timescale 1ns / 1ps

module tb_q_encoding_byte_decoder;

    logic clk;
    logic rst_n;
    logic squeeze_req;
    int   fail_count;
    int   pending;
    int   burst_left;
    int   items_sent;

    qed_in_if  in_ch();
    qed_out_if out_ch();

    q_encoding_byte_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    qed_stream_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #400000;
        $display("** q_encoding_byte_decoder: FAILED **");
        $finish;
    end

    // Random hex digit, mixed case
    function automatic logic [7:0] hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 10)
            return 8'h30 + v;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    // Offer one item, wait for it to be taken, then maybe end the burst
    task automatic offer(input logic [7:0] b, input logic l);
        int gap;
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= l;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_word(input string s);
        for (int i = 0; i < s.len(); i++)
            offer(s[i], i == s.len() - 1);
    endtask

    // One encoded word built from escapes, underscores, stray '=' and noise
    task automatic random_word();
        logic [7:0] word_bytes[$];
        logic [7:0] c;
        int         tokens;
        tokens = $urandom_range(1, 5);
        repeat (tokens)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    word_bytes.push_back(qed_pkg::CH_EQUALS);
                    word_bytes.push_back(hex_char());
                    word_bytes.push_back(hex_char());
                end
                3:
                begin
                    word_bytes.push_back(qed_pkg::CH_EQUALS);
                    word_bytes.push_back(8'($urandom_range(0, 255)));
                    word_bytes.push_back(8'($urandom_range(0, 255)));
                end
                4:
                begin
                    // one good digit, one bad, either order
                    do
                    begin
                        c = 8'($urandom_range(0, 255));
                    end
                    while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
                    word_bytes.push_back(qed_pkg::CH_EQUALS);
                    if ($urandom_range(0, 1))
                    begin
                        word_bytes.push_back(hex_char());
                        word_bytes.push_back(c);
                    end
                    else
                    begin
                        word_bytes.push_back(c);
                        word_bytes.push_back(hex_char());
                    end
                end
                5: word_bytes.push_back(qed_pkg::CH_UNDERSCORE);
                9: word_bytes.push_back(qed_pkg::CH_EQUALS);
                default: word_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        foreach (word_bytes[i])
            offer(word_bytes[i], i == word_bytes.size() - 1);
    endtask

    // Stimulus and verdict
    initial
    begin
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.in_last <= 1'b0;
        rst_n         <= 1'b0;
        squeeze_req   <= 1'b0;
        burst_left    = 1;
        items_sent    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte extremes
        offer(8'h00, 1'b0);
        offer(8'hFF, 1'b1);
        // underscore, then a lower-case escape closing the word
        send_word("_=4a");
        // upper-case escape, then non-hex first digit
        send_word("=F0=g1");
        // non-hex second digit, then underscore held as raw digit
        send_word("=4z=_1");
        // lone '=' ending the word
        send_word("=");
        // '=' second to last, followed by underscore and by '='
        send_word("=_");
        send_word("==");
        // bad escape whose third byte ends the word
        send_word("=A=");

        squeeze_req <= 1'b1;
        while (items_sent < 310)
            random_word();
        in_ch.valid <= 1'b0;
        // let the predictor count the last item
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (fail_count == 0)
            $display("** q_encoding_byte_decoder: PASSED **");
        else
            $display("** q_encoding_byte_decoder: FAILED **");
        $finish;
    end

    // Output side: stall pattern of its own plus one long hold-off
    initial
    begin
        int   mode;
        int   mode_left;
        int   hold_left;
        int   tick;
        bit   squeezed;
        logic rdy;
        out_ch.ready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        squeezed  = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (squeeze_req && !squeezed)
            begin
                squeezed  = 1'b1;
                hold_left = 80;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 80);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 3) != 0);
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = ((tick % 3) != 0);
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

endmodule
